/* hdl/ilei_pkg.sv */
// shared constants, codes and state types for the iso-level edge interpolator
// no dependencies; every other file of the block but ilei_if imports this package
package ilei_pkg;

  // fixed point format and derived widths
  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int RMAG_W    = WORD_W + FRAC_BITS;
  localparam int LO_W      = RMAG_W / 2;
  localparam int HI_W      = RMAG_W - LO_W;
  localparam int DM_W      = WORD_W + 1;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = DM_W + MUL_B_W;
  localparam int PROD_W    = DM_W + RMAG_W;
  localparam int DIV_CNT_W = $clog2(RMAG_W);

  // square root works on the exact sum of three squares
  localparam int SQ_W     = 64;
  localparam int SQRT_TOP = 62;

  // products above this bound saturate
  localparam int SAT_SHIFT = 62;

  // element order in the held and result arrays
  localparam int NUM_ELEM  = 10;
  localparam int ELEM_W    = 4;
  localparam int VORT_BASE = 6;
  localparam int NUM_VORT  = 3;
  localparam int SQ_CNT_W  = 3;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EXTRAP = 2'd1,
    ST_DEGEN  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR,
    S_SQRT1,
    S_SQRT2,
    S_RATIO,
    S_DIV,
    S_LERP,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    PH_DIFF,
    PH_LO,
    PH_HI,
    PH_SUM,
    PH_OUT
  } lerp_ph_e;

endpackage

/* hdl/ilei_if.sv */
// valid/ready channel interfaces: endpoint input, result output, level config
// no dependencies
interface ilei_in_if;
  logic               valid;
  logic               ready;
  logic               endpoint;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] vort_x;
  logic signed [31:0] vort_y;
  logic signed [31:0] vort_z;
  logic signed [31:0] aux_value;

  modport source (output valid, endpoint, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  vort_x, vort_y, vort_z, aux_value, input ready);
  modport sink (input valid, endpoint, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                vort_x, vort_y, vort_z, aux_value, output ready);
endinterface

interface ilei_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [31:0] out_vel_x;
  logic signed [31:0] out_vel_y;
  logic signed [31:0] out_vel_z;
  logic signed [31:0] out_vort_x;
  logic signed [31:0] out_vort_y;
  logic signed [31:0] out_vort_z;
  logic signed [31:0] out_aux;

  modport source (output valid, status, out_pos_x, out_pos_y, out_pos_z, out_vel_x,
                  out_vel_y, out_vel_z, out_vort_x, out_vort_y, out_vort_z, out_aux,
                  input ready);
  modport sink (input valid, status, out_pos_x, out_pos_y, out_pos_z, out_vel_x,
                out_vel_y, out_vel_z, out_vort_x, out_vort_y, out_vort_z, out_aux,
                output ready);
endinterface

interface ilei_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] iso_level;

  modport source (output valid, iso_level, input ready);
  modport sink (input valid, iso_level, output ready);
endinterface

/* hdl/ilei_mul.sv */
// shared unsigned multiplier with registered product
// depends on ilei_pkg
module ilei_mul import ilei_pkg::*; (
  input  logic               clk_i,
  input  logic [DM_W-1:0]    a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [MUL_P_W-1:0] prod_o
);

  logic [MUL_P_W-1:0] prod_q;

  // one product per cycle
  always_ff @(posedge clk_i) begin
    prod_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

/* hdl/ilei_sqrt.sv */
// iterative integer square root, one result bit per cycle
// depends on ilei_pkg
module ilei_sqrt import ilei_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   rad_i,
  output logic              done_o,
  output logic [WORD_W-1:0] root_o
);

  logic [SQ_W-1:0] rem_q, res_q, bit_q, trial;
  logic            busy_q, done_q, ge;

  assign trial = res_q + bit_q;
  assign ge    = rem_q >= trial;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && bit_q[0];
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  // remainder, partial root and test bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rad_i;
      res_q <= '0;
      bit_q <= SQ_W'(1) << SQRT_TOP;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[WORD_W-1:0];

endmodule

/* hdl/ilei_div.sv */
// restoring divider for the crossing ratio, one quotient bit per cycle
// depends on ilei_pkg
module ilei_div import ilei_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RMAG_W-1:0] num_i,
  input  logic [WORD_W-1:0] den_i,
  output logic              done_o,
  output logic [RMAG_W-1:0] quo_o
);

  logic [WORD_W-1:0]    rem_q, den_q;
  logic [RMAG_W-1:0]    quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q, ge;
  logic [WORD_W:0]      part, diff;

  assign part = {rem_q, quo_q[RMAG_W-1]};
  assign diff = part - {1'b0, den_q};
  assign ge   = part >= {1'b0, den_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(RMAG_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // shift in dividend bits, subtract when the divisor fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[WORD_W-1:0] : part[WORD_W-1:0];
      quo_q <= {quo_q[RMAG_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* hdl/iso_level_edge_interpolator.sv */
// iso-level edge interpolator: first endpoint held, second runs the edge
// a second endpoint runs squares, the held then the new square root, ratio, divide,
// per-element interpolate and output load; equal magnitudes skip divide and interpolate
// throughput: one edge at a time; set by the shared square root, divider and multiplier
// a first endpoint is only stored and the block stays idle; input is ready only while idle
// reset: clears level register, held flag, state, sequencer counters and output valid
module iso_level_edge_interpolator import ilei_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilei_cfg_if.sink   cfg_i,
  ilei_in_if.sink    in_i,
  ilei_out_if.source out_o
);

  state_e   state_q, state_d;
  lerp_ph_e ph_q;

  logic [WORD_W-1:0]   iso_q;
  logic [WORD_W-1:0]   in_vec [NUM_ELEM];
  logic [WORD_W-1:0]   held_q [NUM_ELEM];
  logic [WORD_W-1:0]   cur_q  [NUM_ELEM];
  logic [WORD_W-1:0]   res_q  [NUM_ELEM];
  logic [WORD_W-1:0]   out_q  [NUM_ELEM];
  status_e             status_q, out_status_q;
  logic                have_first_q, out_valid_q;
  logic [SQ_CNT_W-1:0] sq_cnt_q;
  logic [ELEM_W-1:0]   elem_q, vidx;
  logic [SQ_W-1:0]     sum1_q, sum2_q;
  logic [WORD_W-1:0]   m1_q, m2_q;
  logic [RMAG_W-1:0]   rmag_q;
  logic                rneg_q, neg_q;
  logic [DM_W-1:0]     dm_q;
  logic [WORD_W-1:0]   a_q;
  logic [PROD_W-1:0]   lo_q, acc_q;

  logic                in_acc, start_edge, out_load;
  logic [DM_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  prod;
  logic [WORD_W-1:0]   vcomp, vabs;
  logic                sqrt_start, sqrt_done, div_start, div_done;
  logic [SQ_W-1:0]     sqrt_rad;
  logic [WORD_W-1:0]   root;
  logic [RMAG_W-1:0]   quo;
  logic [DM_W-1:0]     num, den, numabs, denabs, diff, diffabs;
  logic                in_range;
  logic                ovf;
  logic signed [SQ_W-1:0] a64, q64, s64;
  logic [WORD_W-1:0]   lerp_res;

  // configuration register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_q <= '0;
    end else if (cfg_i.valid) begin
      iso_q <= cfg_i.iso_level;
    end
  end

  // input beat unpacking
  assign in_vec[0] = in_i.pos_x;
  assign in_vec[1] = in_i.pos_y;
  assign in_vec[2] = in_i.pos_z;
  assign in_vec[3] = in_i.vel_x;
  assign in_vec[4] = in_i.vel_y;
  assign in_vec[5] = in_i.vel_z;
  assign in_vec[6] = in_i.vort_x;
  assign in_vec[7] = in_i.vort_y;
  assign in_vec[8] = in_i.vort_z;
  assign in_vec[9] = in_i.aux_value;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign start_edge = in_acc && in_i.endpoint && have_first_q;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // endpoint capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < NUM_ELEM; i++) begin
        if (in_i.endpoint) begin
          cur_q[i] <= in_vec[i];
        end else begin
          held_q[i] <= in_vec[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_first_q <= 1'b0;
    end else if (in_acc) begin
      have_first_q <= !in_i.endpoint;
    end
  end

  // shared multiplier operand select
  assign vidx  = ELEM_W'(VORT_BASE) +
                 ELEM_W'((sq_cnt_q < SQ_CNT_W'(NUM_VORT)) ? sq_cnt_q
                                                          : sq_cnt_q - SQ_CNT_W'(NUM_VORT));
  assign vcomp = (sq_cnt_q < SQ_CNT_W'(NUM_VORT)) ? held_q[vidx] : cur_q[vidx];
  assign vabs  = vcomp[WORD_W-1] ? WORD_W'(0) - vcomp : vcomp;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_SQR) begin
      mul_a = DM_W'(vabs);
      mul_b = MUL_B_W'(vabs);
    end else if (state_q == S_LERP) begin
      mul_a = dm_q;
      mul_b = (ph_q == PH_LO) ? MUL_B_W'(rmag_q[LO_W-1:0]) : MUL_B_W'(rmag_q[RMAG_W-1:LO_W]);
    end
  end

  ilei_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // shared square root, used for the held and then the new vorticity
  assign sqrt_start = ((state_q == S_SQR) && (sq_cnt_q == SQ_CNT_W'(2 * NUM_VORT))) ||
                      ((state_q == S_SQRT1) && sqrt_done);
  assign sqrt_rad   = (state_q == S_SQR) ? sum1_q : sum2_q;

  ilei_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // ratio terms
  assign num    = {1'b0, iso_q} - {1'b0, m1_q};
  assign den    = {1'b0, m2_q} - {1'b0, m1_q};
  assign numabs = num[DM_W-1] ? DM_W'(0) - num : num;
  assign denabs = den[DM_W-1] ? DM_W'(0) - den : den;
  assign in_range = ((iso_q >= m1_q) && (iso_q <= m2_q)) ||
                    ((iso_q >= m2_q) && (iso_q <= m1_q));
  assign div_start = (state_q == S_RATIO) && (m1_q != m2_q);

  ilei_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({numabs[WORD_W-1:0], FRAC_BITS'(0)}),
    .den_i   (denabs[WORD_W-1:0]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // interpolation difference and final saturating add
  assign diff    = {cur_q[elem_q][WORD_W-1], cur_q[elem_q]} -
                   {held_q[elem_q][WORD_W-1], held_q[elem_q]};
  assign diffabs = diff[DM_W-1] ? DM_W'(0) - diff : diff;

  assign ovf = acc_q > (PROD_W'(1) << SAT_SHIFT);
  assign a64 = {{(SQ_W-WORD_W){a_q[WORD_W-1]}}, a_q};
  assign q64 = SQ_W'(acc_q[SAT_SHIFT:FRAC_BITS]);
  assign s64 = neg_q ? a64 - q64 : a64 + q64;

  always_comb begin
    if (ovf || (s64[SQ_W-1:WORD_W-1] != {(SQ_W-WORD_W+1){s64[SQ_W-1]}})) begin
      lerp_res = (ovf ? neg_q : s64[SQ_W-1]) ? {1'b1, {(WORD_W-1){1'b0}}}
                                             : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      lerp_res = s64[WORD_W-1:0];
    end
  end

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_edge) state_d = S_SQR;
      end
      S_SQR: begin
        if (sq_cnt_q == SQ_CNT_W'(2 * NUM_VORT)) state_d = S_SQRT1;
      end
      S_SQRT1: begin
        if (sqrt_done) state_d = S_SQRT2;
      end
      S_SQRT2: begin
        if (sqrt_done) state_d = S_RATIO;
      end
      S_RATIO: begin
        state_d = (m1_q == m2_q) ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (div_done) state_d = S_LERP;
      end
      S_LERP: begin
        if ((ph_q == PH_OUT) && (elem_q == ELEM_W'(NUM_ELEM - 1))) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= '0;
      elem_q   <= '0;
      ph_q     <= PH_DIFF;
    end else begin
      if (state_q == S_SQR) begin
        sq_cnt_q <= sq_cnt_q + 1'b1;
      end else begin
        sq_cnt_q <= '0;
      end
      if (state_q == S_LERP) begin
        unique case (ph_q)
          PH_DIFF: ph_q <= PH_LO;
          PH_LO:   ph_q <= PH_HI;
          PH_HI:   ph_q <= PH_SUM;
          PH_SUM:  ph_q <= PH_OUT;
          PH_OUT: begin
            ph_q   <= PH_DIFF;
            elem_q <= elem_q + 1'b1;
          end
          default: ph_q <= PH_DIFF;
        endcase
      end else begin
        ph_q   <= PH_DIFF;
        elem_q <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    // sum of squares
    if (start_edge) begin
      sum1_q <= '0;
      sum2_q <= '0;
    end else if ((state_q == S_SQR) && (sq_cnt_q != '0)) begin
      if (sq_cnt_q <= SQ_CNT_W'(NUM_VORT)) begin
        sum1_q <= sum1_q + prod[SQ_W-1:0];
      end else begin
        sum2_q <= sum2_q + prod[SQ_W-1:0];
      end
    end
    // magnitudes
    if ((state_q == S_SQRT1) && sqrt_done) m1_q <= root;
    if ((state_q == S_SQRT2) && sqrt_done) m2_q <= root;
    // ratio sign, status and degenerate result
    if (state_q == S_RATIO) begin
      rneg_q <= num[DM_W-1] ^ den[DM_W-1];
      if (m1_q == m2_q) begin
        status_q <= ST_DEGEN;
        for (int i = 0; i < NUM_ELEM; i++) begin
          res_q[i] <= (i < 3) ? held_q[i] : '0;
        end
      end else begin
        status_q <= in_range ? ST_OK : ST_EXTRAP;
      end
    end
    if ((state_q == S_DIV) && div_done) rmag_q <= quo;
    // interpolation steps
    if (state_q == S_LERP) begin
      unique case (ph_q)
        PH_DIFF: begin
          dm_q  <= diffabs;
          neg_q <= diff[DM_W-1] ^ rneg_q;
          a_q   <= held_q[elem_q];
        end
        PH_HI:   lo_q  <= PROD_W'(prod);
        PH_SUM:  acc_q <= lo_q + (PROD_W'(prod) << LO_W);
        PH_OUT:  res_q[elem_q] <= lerp_res;
        default: ;
      endcase
    end
    // output register
    if (out_load) begin
      out_q        <= res_q;
      out_status_q <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output beat
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.out_pos_x  = out_q[0];
  assign out_o.out_pos_y  = out_q[1];
  assign out_o.out_pos_z  = out_q[2];
  assign out_o.out_vel_x  = out_q[3];
  assign out_o.out_vel_y  = out_q[4];
  assign out_o.out_vel_z  = out_q[5];
  assign out_o.out_vort_x = out_q[6];
  assign out_o.out_vort_y = out_q[7];
  assign out_o.out_vort_z = out_q[8];
  assign out_o.out_aux    = out_q[9];

endmodule

/* hdl/ilei_chk.sv */
// port-level checker for the iso-level edge interpolator, bound to the top level
// depends on ilei_pkg and iso_level_edge_interpolator
module ilei_chk import ilei_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [31:0] vel_x_i,
  input logic [31:0] vel_y_i,
  input logic [31:0] vel_z_i,
  input logic [31:0] vort_x_i,
  input logic [31:0] vort_y_i,
  input logic [31:0] vort_z_i,
  input logic [31:0] aux_i
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // a stalled result keeps its status
  a_status_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(status_i))
    else $error("status changed while stalled");

  // a new result only follows a busy period
  a_busy_before_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without edge work");

  // degenerate edges carry zero velocity, vorticity and scalar
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_DEGEN) |->
      (vel_x_i == '0) && (vel_y_i == '0) && (vel_z_i == '0) && (vort_x_i == '0) &&
      (vort_y_i == '0) && (vort_z_i == '0) && (aux_i == '0))
    else $error("degenerate result with nonzero fields");

endmodule

bind iso_level_edge_interpolator ilei_chk u_ilei_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .vel_x_i     (out_o.out_vel_x),
  .vel_y_i     (out_o.out_vel_y),
  .vel_z_i     (out_o.out_vel_z),
  .vort_x_i    (out_o.out_vort_x),
  .vort_y_i    (out_o.out_vort_y),
  .vort_z_i    (out_o.out_vort_z),
  .aux_i       (out_o.out_aux)
);
